>>> rtl/core/clhist_pkg.sv
package clhist_pkg;

    // Fixed field widths
    localparam int VALUE_W   = 16;
    localparam int BIN_W     = 11;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Clamped coordinate, bin span and product widths
    localparam int COORD_W = VALUE_W + 2;
    localparam int DIFF_W  = VALUE_W + 1;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int KEY_W   = PROD_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_SECOND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_SECOND = 3'd4;

    // Request codes
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Sequencer states
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MAP   = 6'b000100,
        S_MUL   = 6'b001000,
        S_IDX   = 6'b010000,
        S_UPD   = 6'b100000
    } state_t;

    // What the update step does with the selected counter
    typedef enum logic [2:0] {
        K_BIN_ADD,
        K_UNDER_ADD,
        K_OVER_ADD,
        K_BIN_READ,
        K_UNDER_READ,
        K_OVER_READ,
        K_DROP
    } kind_t;

    // Map one coordinate onto its clamped bin: 0 below, value-lo+1 inside, hi-lo+2 above
    function automatic coord_t clamp_coord(
        input logic signed [VALUE_W-1:0] c,
        input logic signed [VALUE_W-1:0] lo,
        input logic signed [VALUE_W-1:0] hi
    );
        coord_t c_x;
        coord_t lo_x;
        coord_t hi_x;
        coord_t k;
        c_x  = coord_t'(c);
        lo_x = coord_t'(lo);
        hi_x = coord_t'(hi);
        k    = c_x - lo_x + coord_t'(1);
        if (c > hi) begin
            return hi_x - lo_x + coord_t'(2);
        end
        if (k < 0) begin
            return '0;
        end
        return k;
    endfunction

endpackage

>>> rtl/core/clhist_ram.sv
module clhist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/clamped_histogram_1d_2d.sv
// Histogram engine with a bin memory of BIN_DEPTH saturating counters plus an
// underflow and an overflow counter. After reset the block clears the bin
// memory one entry a cycle, holding busy high until the last entry is clear.
// Each item then runs these steps before the next accept: map the sample,
// multiply row by row span in 2D or pass the offset in 1D, form the bin and
// read the memory, then increment and write back, with the result on the
// ports in the cycle after write-back. Busy stays high until the write-back
// is done, so a single read-modify-write of the bin memory runs at a time and
// no two accesses to one bin overlap. Each item gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it.
module clamped_histogram_1d_2d
    import clhist_pkg::*;
#(
    parameter int BIN_DEPTH   = 1024,
    parameter int COUNT_WIDTH = 32
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_addr,
    input  logic [VALUE_W-1:0]          cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic signed [VALUE_W-1:0]   value_first,
    input  logic signed [VALUE_W-1:0]   value_second,
    input  logic [BIN_W-1:0]            read_index,
    output logic                        done,
    output logic [BIN_W-1:0]            bin_used,
    output logic [COUNT_W-1:0]          count,
    output logic                        dropped
);

    localparam int ADDR_W = $clog2(BIN_DEPTH);
    localparam logic [31:0]            UNDER_BIN = 32'(BIN_DEPTH);
    localparam logic [31:0]            OVER_BIN  = 32'(BIN_DEPTH + 1);
    localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(BIN_DEPTH - 1);
    localparam logic [KEY_W-1:0]       DEPTH_KEY = KEY_W'(BIN_DEPTH);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    // Configuration
    logic                      two_dim_reg;
    logic signed [VALUE_W-1:0] low_first_reg, high_first_reg;
    logic signed [VALUE_W-1:0] low_second_reg, high_second_reg;

    // Item held through the sequence
    logic                      req_reg;
    logic signed [VALUE_W-1:0] v1_reg, v2_reg;
    logic [BIN_W-1:0]          ridx_reg;
    logic                      under_reg, over_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    coord_t                    row_reg, col_reg, span_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    kind_t                     kind_reg;
    logic [BIN_W-1:0]          bin_reg;
    logic [ADDR_W-1:0]         addr_reg;

    // Out-of-store counters
    logic [COUNT_WIDTH-1:0] under_cnt_reg, over_cnt_reg;

    // Result
    logic                done_reg;
    logic [BIN_W-1:0]    bin_used_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                dropped_reg;

    // Combinational terms
    coord_t                   row_c, col_c, span_c, hs_x, ls_x;
    logic signed [DIFF_W-1:0] v1_x, lo1_x, diff_c;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [KEY_W-1:0]  key_c, prod_ext, col_ext;
    logic                     in_store;
    logic [31:0]              ridx_w;
    kind_t                    kind_c;
    logic [BIN_W-1:0]         bin_c;
    logic [ADDR_W-1:0]        raddr_c;
    logic [COUNT_WIDTH-1:0]   cur_c, inc_c, res_c;
    logic [63:0]              res_w;
    logic                     is_add;

    // Memory port
    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign bin_used = bin_used_reg;
    assign count    = count_reg;
    assign dropped  = dropped_reg;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:   state_next = S_MUL;
            S_MUL:   state_next = S_IDX;
            S_IDX:   state_next = S_UPD;
            S_UPD:   state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Take configuration writes, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_dim_reg     <= 1'b0;
            low_first_reg   <= '0;
            high_first_reg  <= '0;
            low_second_reg  <= '0;
            high_second_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MODE:        two_dim_reg     <= cfg_wdata[0];
                REG_LOW_FIRST:   low_first_reg   <= cfg_wdata;
                REG_HIGH_FIRST:  high_first_reg  <= cfg_wdata;
                REG_LOW_SECOND:  low_second_reg  <= cfg_wdata;
                REG_HIGH_SECOND: high_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Map the sample onto clamped coordinates and the 1D offset
    always_comb
    begin
        row_c  = clamp_coord(v1_reg, low_first_reg, high_first_reg);
        col_c  = clamp_coord(v2_reg, low_second_reg, high_second_reg);
        hs_x   = coord_t'(high_second_reg);
        ls_x   = coord_t'(low_second_reg);
        span_c = hs_x - ls_x + coord_t'(3);
        v1_x   = DIFF_W'(v1_reg);
        lo1_x  = DIFF_W'(low_first_reg);
        diff_c = v1_x - lo1_x;
    end

    // Multiply row by span in 2D, pass the offset in 1D
    always_comb
    begin
        if (two_dim_reg)
        begin
            prod_c = span_reg * row_reg;
        end
        else
        begin
            prod_c = PROD_W'(diff_reg);
        end
    end

    // Form the bin and pick the counter
    always_comb
    begin
        prod_ext = KEY_W'(prod_reg);
        col_ext  = two_dim_reg ? KEY_W'(col_reg) : '0;
        key_c    = prod_ext + col_ext;
        in_store = !key_c[KEY_W-1] && ($unsigned(key_c) < DEPTH_KEY);
        ridx_w   = 32'(ridx_reg);
        kind_c   = K_DROP;
        bin_c    = '0;
        if (req_reg == REQ_READ)
        begin
            if (ridx_w < UNDER_BIN)
            begin
                kind_c = K_BIN_READ;
                bin_c  = ridx_reg;
            end
            else if (ridx_w == UNDER_BIN)
            begin
                kind_c = K_UNDER_READ;
                bin_c  = ridx_reg;
            end
            else if (ridx_w == OVER_BIN)
            begin
                kind_c = K_OVER_READ;
                bin_c  = ridx_reg;
            end
        end
        else if (!two_dim_reg && under_reg)
        begin
            kind_c = K_UNDER_ADD;
            bin_c  = UNDER_BIN[BIN_W-1:0];
        end
        else if (!two_dim_reg && over_reg)
        begin
            kind_c = K_OVER_ADD;
            bin_c  = OVER_BIN[BIN_W-1:0];
        end
        else if (in_store)
        begin
            kind_c = K_BIN_ADD;
            bin_c  = key_c[BIN_W-1:0];
        end
        if (kind_c == K_BIN_READ)
        begin
            raddr_c = ridx_w[ADDR_W-1:0];
        end
        else
        begin
            raddr_c = key_c[ADDR_W-1:0];
        end
    end

    // Increment with saturation
    always_comb
    begin
        is_add = 1'b0;
        case (kind_reg)
            K_BIN_ADD:    begin cur_c = ram_rdata;     is_add = 1'b1; end
            K_UNDER_ADD:  begin cur_c = under_cnt_reg; is_add = 1'b1; end
            K_OVER_ADD:   begin cur_c = over_cnt_reg;  is_add = 1'b1; end
            K_BIN_READ:   cur_c = ram_rdata;
            K_UNDER_READ: cur_c = under_cnt_reg;
            K_OVER_READ:  cur_c = over_cnt_reg;
            default:      cur_c = '0;
        endcase
        inc_c = (cur_c == COUNT_MAX) ? cur_c : cur_c + COUNT_WIDTH'(1);
        res_c = is_add ? inc_c : cur_c;
        res_w = 64'(res_c);
    end

    // Hold the item and the values of each step
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg  <= req_type;
            v1_reg   <= value_first;
            v2_reg   <= value_second;
            ridx_reg <= read_index;
        end
        if (state_reg == S_MAP)
        begin
            under_reg <= (v1_reg < low_first_reg);
            over_reg  <= (high_first_reg < v1_reg);
            diff_reg  <= diff_c;
            row_reg   <= row_c;
            col_reg   <= col_c;
            span_reg  <= span_c;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_c;
        end
        if (state_reg == S_IDX)
        begin
            kind_reg <= kind_c;
            bin_reg  <= bin_c;
            addr_reg <= raddr_c;
        end
        if (state_reg == S_UPD)
        begin
            bin_used_reg <= bin_reg;
            count_reg    <= res_w[COUNT_W-1:0];
            dropped_reg  <= (kind_reg == K_DROP);
        end
    end

    // Update the out-of-store counters and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            under_cnt_reg <= '0;
            over_cnt_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_UPD);
            if (state_reg == S_UPD && kind_reg == K_UNDER_ADD)
            begin
                under_cnt_reg <= inc_c;
            end
            if (state_reg == S_UPD && kind_reg == K_OVER_ADD)
            begin
                over_cnt_reg <= inc_c;
            end
        end
    end

    // Clear the bin memory after reset, then write back increments
    assign ram_re    = (state_reg == S_IDX);
    assign ram_we    = (state_reg == S_CLEAR) ||
                       (state_reg == S_UPD && kind_reg == K_BIN_ADD);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : inc_c;

    clhist_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_DEPTH)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr_c),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_UPD))
        else $error("result strobe without a preceding update step");

    a_accept_to_map: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_MAP))
        else $error("accepted item did not enter the map step");

    a_drop_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> (count == '0 && bin_used == '0))
        else $error("dropped item reports a bin or a count");

    a_ram_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_UPD))
        else $error("bin memory written outside clear or write-back");
`endif

endmodule
